// File: src/mcwk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwk_pkg: shared types and constants of the mean color window keyer
// Widths, command word format between front and back, divider interface.
// ----------------------------------------------------------------------------
package mcwk_pkg;

	// Learning capacity; the sum and count widths follow from it.
	localparam longint unsigned MAX_LEARN_PIXELS = 64'd1048576;
	localparam int CNT_W = $clog2(MAX_LEARN_PIXELS + 1);
	localparam int SUM_W = $clog2(MAX_LEARN_PIXELS * 255 + 1);

	localparam int PIX_W    = 8;
	localparam int TDATA_W  = 3 * PIX_W;
	localparam int WIN_W    = 9;
	localparam int PCT_W    = 7;

	localparam logic [PCT_W-1:0] PCT_LOW  = 7'd87;
	localparam logic [PCT_W-1:0] PCT_HIGH = 7'd113;
	localparam logic [PCT_W-1:0] PCT_DEN  = 7'd100;

	// Divider widths: numerator is sum*percent, denominator is count*100.
	localparam int PROD_W = SUM_W + PCT_W;
	localparam int DEN_W  = CNT_W + PCT_W;
	localparam int DSH_W  = DEN_W + WIN_W - 1;
	localparam int CMP_W  = (PROD_W > DSH_W) ? PROD_W : DSH_W;
	localparam int STEP_W = $clog2(WIN_W);

	// Six window bounds: low/high for red, green, blue.
	localparam int NUM_BOUNDS = 6;
	localparam int BIDX_W     = $clog2(NUM_BOUNDS);

	// Command queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Input word kinds carried on tuser.
	localparam logic REQ_LEARN = 1'b0;
	localparam logic REQ_KEY   = 1'b1;

	typedef enum logic {
		CMD_KEY,
		CMD_WIN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [PIX_W-1:0]       red;
		logic [PIX_W-1:0]       green;
		logic [PIX_W-1:0]       blue;
		logic [SUM_W-1:0]       sum_red;
		logic [SUM_W-1:0]       sum_green;
		logic [SUM_W-1:0]       sum_blue;
		logic [CNT_W-1:0]       count;
	} cmd_t;

	typedef struct packed {
		logic                   start;
		logic [PROD_W-1:0]      num;
		logic [DEN_W-1:0]       den;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [WIN_W-1:0]       quo;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_WAIT
	} back_state_t;

endpackage

// File: src/mean_color_window_keyer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_color_window_keyer: color keyer with windows learned from a mean
// Learns per-channel mean windows and passes or blanks pixels to key.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ channel. tuser = 0 marks a learn pixel, which
//   is added to the running red, green and blue sums; tlast = 1 on a learn
//   pixel closes learning, and each channel's window becomes
//   floor(sum*87/(100*count)) .. floor(sum*113/(100*count)). tuser = 1 marks a
//   pixel to key; tlast is ignored on it. Each key word yields one output word
//   on the m_ channel: the pixel if all three channels lie inside their
//   windows (tuser = 1), else black (tuser = 0). Learn words yield nothing.
// Throughput:
//   Learn and key words are accepted one per cycle while the queue is not full.
//   A key word with nothing queued ahead passes the queue, then the output register.
//   Closing a learn set occupies the back end: a dispatch state, then for each of
//   the six bounds a multiply state, a load state, the divider run and a write-back;
//   meanwhile the front keeps accepting until the four-entry queue fills.
// Reset and stall:
//   Reset clears the sums, the count and all windows, so before any learning
//   only the pixel (0,0,0) passes. A stalled receiver holds the output word;
//   the queue then fills and s_tready falls until words drain.
// ----------------------------------------------------------------------------
module mean_color_window_keyer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mcwk_pkg::TDATA_W-1:0]  s_tdata,   // red, green, blue
	input  logic                          s_tuser,   // req_type
	input  logic                          s_tlast,   // last learn pixel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mcwk_pkg::TDATA_W-1:0]  m_tdata,   // red_out, green_out, blue_out
	output logic                          m_tuser    // inside_res
);

	// Front to back command queue.
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_nempty;
	mcwk_pkg::cmd_t       q_wdata;
	mcwk_pkg::cmd_t       q_rdata;

	// Shared divider for the window bounds.
	mcwk_pkg::div_req_t   div_req;
	mcwk_pkg::div_rsp_t   div_rsp;

	// The front sums learn pixels and queues key pixels and, on the last
	// learn pixel, a snapshot of the final sums and count.
	mcwk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	mcwk_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.nempty (q_nempty)
	);

	// The back runs commands strictly in order, so key pixels queued before
	// a window update are judged against the old windows.
	mcwk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_nempty (q_nempty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

	mcwk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// File: src/mcwk_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwk_fifo: command queue between front and back
// Small register queue; the front pushes only when not full.
// ----------------------------------------------------------------------------
module mcwk_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mcwk_pkg::cmd_t  wdata,
	output logic            full,
	input  logic            pop,
	output mcwk_pkg::cmd_t  rdata,
	output logic            nempty
);

	mcwk_pkg::cmd_t                   mem_q [mcwk_pkg::QDEPTH];
	logic [mcwk_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mcwk_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mcwk_pkg::QCNT_W-1:0]      cnt_q;

	assign full   = (cnt_q == mcwk_pkg::QCNT_W'(mcwk_pkg::QDEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// File: src/mcwk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwk_front: input acceptance and learn accumulation
// Sums learn words, and queues key words and window computations.
// ----------------------------------------------------------------------------
module mcwk_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mcwk_pkg::TDATA_W-1:0]  s_tdata,
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	input  logic                          q_full,
	output logic                          q_push,
	output mcwk_pkg::cmd_t                q_wdata
);

	logic [mcwk_pkg::SUM_W-1:0]  sum_red_q, sum_green_q, sum_blue_q;
	logic [mcwk_pkg::SUM_W-1:0]  sum_red_n, sum_green_n, sum_blue_n;
	logic [mcwk_pkg::CNT_W-1:0]  cnt_q, cnt_n;
	logic [mcwk_pkg::PIX_W-1:0]  red, green, blue;
	logic                        acc;
	logic                        add;

	assign red   = s_tdata[mcwk_pkg::PIX_W-1:0];
	assign green = s_tdata[2*mcwk_pkg::PIX_W-1:mcwk_pkg::PIX_W];
	assign blue  = s_tdata[3*mcwk_pkg::PIX_W-1:2*mcwk_pkg::PIX_W];

	assign s_tready = !q_full;
	assign acc      = s_tvalid && !q_full;
	// Once the count reaches capacity, further learn pixels are dropped.
	assign add      = (cnt_q < mcwk_pkg::CNT_W'(mcwk_pkg::MAX_LEARN_PIXELS));

	always_comb begin
		sum_red_n   = add ? sum_red_q   + mcwk_pkg::SUM_W'(red)   : sum_red_q;
		sum_green_n = add ? sum_green_q + mcwk_pkg::SUM_W'(green) : sum_green_q;
		sum_blue_n  = add ? sum_blue_q  + mcwk_pkg::SUM_W'(blue)  : sum_blue_q;
		cnt_n       = add ? cnt_q + 1'b1 : cnt_q;

		q_push = acc && ((s_tuser == mcwk_pkg::REQ_KEY) || s_tlast);

		q_wdata.kind      = (s_tuser == mcwk_pkg::REQ_KEY) ? mcwk_pkg::CMD_KEY
		                                                  : mcwk_pkg::CMD_WIN;
		q_wdata.red       = red;
		q_wdata.green     = green;
		q_wdata.blue      = blue;
		q_wdata.sum_red   = sum_red_n;
		q_wdata.sum_green = sum_green_n;
		q_wdata.sum_blue  = sum_blue_n;
		q_wdata.count     = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_red_q   <= '0;
			sum_green_q <= '0;
			sum_blue_q  <= '0;
			cnt_q       <= '0;
		end else if (acc && (s_tuser == mcwk_pkg::REQ_LEARN)) begin
			if (s_tlast) begin
				sum_red_q   <= '0;
				sum_green_q <= '0;
				sum_blue_q  <= '0;
				cnt_q       <= '0;
			end else begin
				sum_red_q   <= sum_red_n;
				sum_green_q <= sum_green_n;
				sum_blue_q  <= sum_blue_n;
				cnt_q       <= cnt_n;
			end
		end
	end

endmodule

// File: src/mcwk_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwk_div: restoring divider for the window bounds
// One quotient bit per cycle; the quotient always fits in the window width.
// ----------------------------------------------------------------------------
module mcwk_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mcwk_pkg::div_req_t  req,
	output mcwk_pkg::div_rsp_t  rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [mcwk_pkg::STEP_W-1:0]   step_q;
	logic [mcwk_pkg::CMP_W-1:0]    rem_q;
	logic [mcwk_pkg::CMP_W-1:0]    dsh_q;
	logic [mcwk_pkg::WIN_W-1:0]    quo_q;
	logic                          ge;

	assign ge       = (rem_q >= dsh_q);
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= mcwk_pkg::STEP_W'(mcwk_pkg::WIN_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= mcwk_pkg::CMP_W'(req.num);
			dsh_q <= mcwk_pkg::CMP_W'(req.den) << (mcwk_pkg::WIN_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[mcwk_pkg::WIN_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

// File: src/mcwk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwk_back: window computation and keying
// Runs queued commands in order: keys a pixel or recomputes the six bounds.
// ----------------------------------------------------------------------------
module mcwk_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_nempty,
	input  mcwk_pkg::cmd_t                q_rdata,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mcwk_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tuser,
	output mcwk_pkg::div_req_t            div_req,
	input  mcwk_pkg::div_rsp_t            div_rsp
);

	mcwk_pkg::back_state_t          state_q, state_d;
	logic [mcwk_pkg::BIDX_W-1:0]    bidx_q;
	logic [mcwk_pkg::WIN_W-1:0]     win_q [mcwk_pkg::NUM_BOUNDS];
	logic [mcwk_pkg::PROD_W-1:0]    prod_q;
	logic [mcwk_pkg::DEN_W-1:0]     den_q;
	logic                           out_valid_q;
	logic [mcwk_pkg::TDATA_W-1:0]   out_data_q;
	logic                           out_user_q;
	logic [mcwk_pkg::SUM_W-1:0]     sum_sel;
	logic [mcwk_pkg::PCT_W-1:0]     pct_sel;
	logic                           out_free;
	logic                           key_take;
	logic                           bound_done;
	logic                           bidx_last;
	logic                           in_win;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	assign out_free  = !out_valid_q || m_tready;
	assign bidx_last = (bidx_q == mcwk_pkg::BIDX_W'(mcwk_pkg::NUM_BOUNDS - 1));

	// Bounds are ordered low/high for red, then green, then blue.
	assign in_win =
		(mcwk_pkg::WIN_W'(q_rdata.red)   >= win_q[0]) &&
		(mcwk_pkg::WIN_W'(q_rdata.red)   <= win_q[1]) &&
		(mcwk_pkg::WIN_W'(q_rdata.green) >= win_q[2]) &&
		(mcwk_pkg::WIN_W'(q_rdata.green) <= win_q[3]) &&
		(mcwk_pkg::WIN_W'(q_rdata.blue)  >= win_q[4]) &&
		(mcwk_pkg::WIN_W'(q_rdata.blue)  <= win_q[5]);

	always_comb begin
		case (bidx_q[mcwk_pkg::BIDX_W-1:1])
			2'd0:    sum_sel = q_rdata.sum_red;
			2'd1:    sum_sel = q_rdata.sum_green;
			default: sum_sel = q_rdata.sum_blue;
		endcase
		pct_sel = bidx_q[0] ? mcwk_pkg::PCT_HIGH : mcwk_pkg::PCT_LOW;
	end

	always_comb begin
		state_d       = state_q;
		q_pop         = 1'b0;
		key_take      = 1'b0;
		bound_done    = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = prod_q;
		div_req.den   = den_q;
		case (state_q)
			mcwk_pkg::ST_IDLE: begin
				if (q_nempty) begin
					if (q_rdata.kind == mcwk_pkg::CMD_KEY) begin
						if (out_free) begin
							q_pop    = 1'b1;
							key_take = 1'b1;
						end
					end else begin
						state_d = mcwk_pkg::ST_MUL;
					end
				end
			end
			mcwk_pkg::ST_MUL: begin
				state_d = mcwk_pkg::ST_LOAD;
			end
			mcwk_pkg::ST_LOAD: begin
				div_req.start = 1'b1;
				state_d       = mcwk_pkg::ST_WAIT;
			end
			mcwk_pkg::ST_WAIT: begin
				if (div_rsp.done) begin
					bound_done = 1'b1;
					if (bidx_last) begin
						q_pop   = 1'b1;
						state_d = mcwk_pkg::ST_IDLE;
					end else begin
						state_d = mcwk_pkg::ST_MUL;
					end
				end
			end
			default: begin
				state_d = mcwk_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mcwk_pkg::ST_IDLE;
			bidx_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < mcwk_pkg::NUM_BOUNDS; i++)
				win_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (key_take)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (bound_done) begin
				// An empty learn set leaves every bound at zero.
				win_q[bidx_q] <= (den_q == '0) ? '0 : div_rsp.quo;
				bidx_q        <= bidx_last ? '0 : bidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mcwk_pkg::ST_MUL) begin
			prod_q <= mcwk_pkg::PROD_W'(sum_sel) * mcwk_pkg::PROD_W'(pct_sel);
			den_q  <= mcwk_pkg::DEN_W'(q_rdata.count) * mcwk_pkg::DEN_W'(mcwk_pkg::PCT_DEN);
		end
		if (key_take) begin
			out_data_q <= in_win ? {q_rdata.blue, q_rdata.green, q_rdata.red} : '0;
			out_user_q <= in_win;
		end
	end

endmodule
